[rtl/prime_sieve_bitmap_defines.svh]
// assertion macros of the prime sieve rtl
`ifndef PRIME_SIEVE_BITMAP_DEFINES_SVH
`define PRIME_SIEVE_BITMAP_DEFINES_SVH

// concurrent check, switched off while reset is asserted
`define PSB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent check that also holds during reset
`define PSB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/psb_pkg.sv]
// shared types, constants and helpers of the prime sieve
package psb_pkg;

  localparam int NUM_W         = 9;
  localparam int WORD_BITS     = 32;
  localparam int BIT_W         = 5;
  localparam int WIDX_W        = NUM_W - BIT_W;
  localparam int MAX_LIMIT_DEF = 256;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_MARK,
    OP_READ
  } cmd_op_e;

  // command travelling down the cell chain; hops counts down to the target word
  typedef struct packed {
    logic                 vld;
    cmd_op_e              op;
    logic [WIDX_W-1:0]    hops;
    logic [BIT_W-1:0]     bit_idx;
    logic [WORD_BITS-1:0] data;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MARK,
    ST_ADV_REQ,
    ST_ADV_WAIT,
    ST_SCAN_REQ,
    ST_SCAN_WAIT,
    ST_EMIT,
    ST_FLUSH
  } psb_state_e;

  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] idx;
  } find_t;

  // lowest set bit of a word
  function automatic find_t find_lowest(input logic [WORD_BITS-1:0] v);
    find_t r;
    r.found = |v;
    r.idx   = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        r.idx = BIT_W'(i);
      end
    end
    return r;
  endfunction

endpackage

[rtl/psb_if.sv]
// valid/ready channel interfaces of the prime sieve
interface psb_in_if;
  logic                       valid;
  logic                       ready;
  logic [psb_pkg::NUM_W-1:0]  limit;

  modport source (output valid, output limit, input ready);
  modport sink   (input valid, input limit, output ready);
endinterface

interface psb_out_if;
  logic                       valid;
  logic                       ready;
  logic [psb_pkg::NUM_W-1:0]  prime;
  logic                       last;

  modport source (output valid, output prime, output last, input ready);
  modport sink   (input valid, input prime, input last, output ready);
endinterface

[rtl/prime_sieve_bitmap.sv]
// sieve of eratosthenes over a bitmap held in a chain of word cells
// One input beat carries a limit; the block then sends every prime from 2 up to that limit
// in ascending order, one per output beat, with last set on the largest one. Limits below
// 2 give no output beats, limits above MAX_LIMIT are treated as MAX_LIMIT. The bitmap lives
// in a row of WORDS cells of 32 bits each; commands (clear, mark, read) enter the first cell
// and pass through the register of every cell in turn before a read word comes back.
// A run marks the multiples 2p, 3p, .. of every prime p up to limit/2, reads words while
// stepping to the next prime, and then scans every word up to the limit to send the primes;
// the output side can stall the run. The input is taken only while the block is idle;
// the final beat of a run may still wait in the output register while the next limit
// is accepted.
`include "prime_sieve_bitmap_defines.svh"

module prime_sieve_bitmap #(
  parameter int MAX_LIMIT = psb_pkg::MAX_LIMIT_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  psb_in_if.sink    in_i,
  psb_out_if.source out_o
);

  localparam int NUM_W     = psb_pkg::NUM_W;
  localparam int WORD_BITS = psb_pkg::WORD_BITS;
  localparam int BIT_W     = psb_pkg::BIT_W;
  localparam int WIDX_W    = psb_pkg::WIDX_W;
  // bit k of the map stands for number k+2
  localparam int WORDS     = (MAX_LIMIT + WORD_BITS - 2) / WORD_BITS;

  localparam logic [NUM_W-1:0] LIM_MAX     = NUM_W'(MAX_LIMIT);
  localparam logic [NUM_W-1:0] FIRST_PRIME = NUM_W'(2);

  // control state
  psb_pkg::psb_state_e state_q, state_d;
  logic                hold_vld_q, hold_vld_d;
  logic                out_vld_q, out_vld_d;

  // run data
  logic [NUM_W-1:0]     lim_q, lim_d;
  logic [NUM_W-1:0]     p_q, p_d;          // prime being marked
  logic [NUM_W-1:0]     m_q, m_d;          // next multiple to mark
  logic [NUM_W-1:0]     cand_q, cand_d;    // first number to test for the next prime
  logic [WIDX_W-1:0]    widx_q, widx_d;    // word under scan
  logic [WORD_BITS-1:0] mask_q, mask_d;    // primes still to send from that word
  logic [NUM_W-1:0]     hold_prime_q, hold_prime_d;
  logic [NUM_W-1:0]     out_prime_q, out_prime_d;
  logic                 out_last_q, out_last_d;

  // cell chain
  psb_pkg::cmd_t chain [0:WORDS];
  psb_pkg::cmd_t cmd_issue;
  psb_pkg::cmd_t rd;
  logic          rd_is_read;

  // helpers
  logic [NUM_W-1:0]     m_k, cand_k, lim_k;
  logic [WIDX_W-1:0]    end_widx;
  logic [WORD_BITS-1:0] adv_free;
  psb_pkg::find_t       adv_find;
  logic [NUM_W-1:0]     adv_num;
  logic [NUM_W:0]       adv_dbl;
  logic [NUM_W-1:0]     adv_next;
  logic [WORD_BITS-1:0] range_mask;
  psb_pkg::find_t       scan_find;
  logic [NUM_W-1:0]     scan_num;
  logic                 out_load;
  logic                 rd_expected;

  assign chain[0] = cmd_issue;

  for (genvar gi = 0; gi < WORDS; gi++) begin : g_cell
    psb_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (chain[gi]),
      .cmd_o  (chain[gi+1])
    );
  end

  assign rd         = chain[WORDS];
  assign rd_is_read = rd.vld && (rd.op == psb_pkg::OP_READ);

  assign m_k      = m_q - FIRST_PRIME;
  assign cand_k   = cand_q - FIRST_PRIME;
  assign lim_k    = lim_q - FIRST_PRIME;
  assign end_widx = lim_k[NUM_W-1:BIT_W];

  // next prime: lowest unmarked bit at or above the candidate in the returned word
  assign adv_free = ~rd.data & ({WORD_BITS{1'b1}} << cand_k[BIT_W-1:0]);
  assign adv_find = psb_pkg::find_lowest(adv_free);
  assign adv_num  = {cand_k[NUM_W-1:BIT_W], adv_find.idx} + FIRST_PRIME;
  assign adv_dbl  = {adv_num, 1'b0};
  assign adv_next = {cand_k[NUM_W-1:BIT_W] + WIDX_W'(1), BIT_W'(0)} + FIRST_PRIME;

  // numbers of the scanned word that do not exceed the limit
  always_comb begin
    if (widx_q < end_widx) begin
      range_mask = {WORD_BITS{1'b1}};
    end else if (widx_q == end_widx) begin
      range_mask = {WORD_BITS{1'b1}} >> (~lim_k[BIT_W-1:0]);
    end else begin
      range_mask = '0;
    end
  end

  assign scan_find = psb_pkg::find_lowest(mask_q);
  assign scan_num  = {widx_q, scan_find.idx} + FIRST_PRIME;

  // output register can take a beat this cycle
  assign out_load = !out_vld_q || out_o.ready;

  assign in_i.ready = (state_q == psb_pkg::ST_IDLE);

  always_comb begin
    state_d      = state_q;
    lim_d        = lim_q;
    p_d          = p_q;
    m_d          = m_q;
    cand_d       = cand_q;
    widx_d       = widx_q;
    mask_d       = mask_q;
    hold_vld_d   = hold_vld_q;
    hold_prime_d = hold_prime_q;
    out_vld_d    = out_vld_q && !out_o.ready;
    out_prime_d  = out_prime_q;
    out_last_d   = out_last_q;
    cmd_issue    = '0;

    unique case (state_q)
      psb_pkg::ST_IDLE: begin
        if (in_i.valid && (in_i.limit >= FIRST_PRIME)) begin
          lim_d        = (in_i.limit > LIM_MAX) ? LIM_MAX : in_i.limit;
          cmd_issue.vld = 1'b1;
          cmd_issue.op  = psb_pkg::OP_CLEAR;
          p_d          = FIRST_PRIME;
          m_d          = FIRST_PRIME + FIRST_PRIME;
          state_d      = psb_pkg::ST_MARK;
        end
      end

      psb_pkg::ST_MARK: begin
        if (m_q <= lim_q) begin
          cmd_issue.vld     = 1'b1;
          cmd_issue.op      = psb_pkg::OP_MARK;
          cmd_issue.hops    = m_k[NUM_W-1:BIT_W];
          cmd_issue.bit_idx = m_k[BIT_W-1:0];
          m_d               = m_q + p_q;
        end else begin
          cand_d  = p_q + NUM_W'(1);
          state_d = psb_pkg::ST_ADV_REQ;
        end
      end

      psb_pkg::ST_ADV_REQ: begin
        cmd_issue.vld  = 1'b1;
        cmd_issue.op   = psb_pkg::OP_READ;
        cmd_issue.hops = cand_k[NUM_W-1:BIT_W];
        state_d        = psb_pkg::ST_ADV_WAIT;
      end

      psb_pkg::ST_ADV_WAIT: begin
        if (rd_is_read) begin
          if (adv_find.found) begin
            if (adv_dbl > {1'b0, lim_q}) begin
              // no multiple left to mark for this or any later prime
              widx_d  = '0;
              state_d = psb_pkg::ST_SCAN_REQ;
            end else begin
              p_d     = adv_num;
              m_d     = adv_num + adv_num;
              state_d = psb_pkg::ST_MARK;
            end
          end else if (adv_next > lim_q) begin
            widx_d  = '0;
            state_d = psb_pkg::ST_SCAN_REQ;
          end else begin
            cand_d  = adv_next;
            state_d = psb_pkg::ST_ADV_REQ;
          end
        end
      end

      psb_pkg::ST_SCAN_REQ: begin
        cmd_issue.vld  = 1'b1;
        cmd_issue.op   = psb_pkg::OP_READ;
        cmd_issue.hops = widx_q;
        state_d        = psb_pkg::ST_SCAN_WAIT;
      end

      psb_pkg::ST_SCAN_WAIT: begin
        if (rd_is_read) begin
          mask_d  = ~rd.data & range_mask;
          state_d = psb_pkg::ST_EMIT;
        end
      end

      psb_pkg::ST_EMIT: begin
        if (scan_find.found) begin
          // one prime is held back so the largest can carry last
          if (!hold_vld_q) begin
            hold_vld_d   = 1'b1;
            hold_prime_d = scan_num;
            mask_d       = mask_q & (mask_q - WORD_BITS'(1));
          end else if (out_load) begin
            out_vld_d    = 1'b1;
            out_prime_d  = hold_prime_q;
            out_last_d   = 1'b0;
            hold_prime_d = scan_num;
            mask_d       = mask_q & (mask_q - WORD_BITS'(1));
          end
        end else if (widx_q == end_widx) begin
          state_d = psb_pkg::ST_FLUSH;
        end else begin
          widx_d  = widx_q + WIDX_W'(1);
          state_d = psb_pkg::ST_SCAN_REQ;
        end
      end

      psb_pkg::ST_FLUSH: begin
        if (out_load) begin
          out_vld_d   = 1'b1;
          out_prime_d = hold_prime_q;
          out_last_d  = 1'b1;
          hold_vld_d  = 1'b0;
          state_d     = psb_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = psb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= psb_pkg::ST_IDLE;
      hold_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      hold_vld_q <= hold_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lim_q        <= lim_d;
    p_q          <= p_d;
    m_q          <= m_d;
    cand_q       <= cand_d;
    widx_q       <= widx_d;
    mask_q       <= mask_d;
    hold_prime_q <= hold_prime_d;
    out_prime_q  <= out_prime_d;
    out_last_q   <= out_last_d;
  end

  assign out_o.valid = out_vld_q;
  assign out_o.prime = out_prime_q;
  assign out_o.last  = out_last_q;

  // a read beat leaves the chain only while the controller waits for it
  assign rd_expected = (state_q == psb_pkg::ST_ADV_WAIT) || (state_q == psb_pkg::ST_SCAN_WAIT);

  `PSB_ASSERT(a_rd_wait, clk_i, rst_ni, rd_is_read |-> rd_expected, "stray read beat")
  `PSB_ASSERT(a_hold_range, clk_i, rst_ni,
              hold_vld_q |-> (hold_prime_q <= lim_q), "held prime above limit")
  `PSB_ASSERT(a_ascend, clk_i, rst_ni,
              (hold_vld_q && out_vld_q && !out_last_q) |-> (out_prime_q < hold_prime_q),
              "primes out of order")
  `PSB_ASSERT_ALWAYS(a_idle_empty, clk_i,
                     (state_q == psb_pkg::ST_IDLE) |-> !hold_vld_q, "prime held while idle")
  `PSB_ASSERT(a_flush_last, clk_i, rst_ni,
              ((state_q == psb_pkg::ST_FLUSH) && out_load) |=> (out_vld_q && out_last_q),
              "final beat not flagged")

endmodule

[rtl/psb_cell.sv]
// one bitmap word of the sieve, applies and forwards chain commands
module psb_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  psb_pkg::cmd_t cmd_i,
  output psb_pkg::cmd_t cmd_o
);

  localparam int WIDX_W    = psb_pkg::WIDX_W;
  localparam int WORD_BITS = psb_pkg::WORD_BITS;

  logic [WORD_BITS-1:0] word_q, word_d;
  psb_pkg::cmd_t        cmd_q, cmd_d;
  logic                 hit;

  assign hit = (cmd_i.hops == '0);

  always_comb begin
    word_d     = word_q;
    cmd_d      = cmd_i;
    cmd_d.hops = cmd_i.hops - WIDX_W'(1);
    if (cmd_i.vld) begin
      unique case (cmd_i.op)
        psb_pkg::OP_CLEAR: begin
          word_d = '0;
        end
        psb_pkg::OP_MARK: begin
          if (hit) begin
            word_d[cmd_i.bit_idx] = 1'b1;
          end
        end
        psb_pkg::OP_READ: begin
          if (hit) begin
            cmd_d.data = word_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q <= '0;
    end else begin
      cmd_q <= cmd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign cmd_o = cmd_q;

endmodule
